@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SLCD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Check a property on every rising clock edge, reset included.
`define SLCD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");

`endif

@@ rtl/slcd_pkg.sv @@
package slcd_pkg;

	localparam int FRAME_BITS = 16;
	localparam int CNT_W = $clog2(FRAME_BITS);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] BP_BIT = 8'h80;
	localparam logic [7:0] LOW7 = 8'h7f;

	// Reciprocal for an 8-bit divide by ten: q = (v * 205) >> 11.
	localparam logic [7:0] DIV10_MUL = 8'd205;
	localparam int DIV10_SHIFT = 11;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_LOAD_DEC = 2'd1,
		CMD_LOAD_HEX = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] value;
	} in_t;

	typedef struct packed {
		logic serial_bit;
		logic strobe_after;
	} out_t;

	// Front to queue: one frame write.
	typedef struct packed {
		logic push;
		logic [FRAME_BITS-1:0] frame;
	} frame_req_t;

	// Queue head as seen by the serializer.
	typedef struct packed {
		logic empty;
		logic [FRAME_BITS-1:0] frame;
	} frame_head_t;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] s;
		case (digit)
			4'h0: s = 8'h3f;
			4'h1: s = 8'h06;
			4'h2: s = 8'h5b;
			4'h3: s = 8'h4f;
			4'h4: s = 8'h66;
			4'h5: s = 8'h6d;
			4'h6: s = 8'h7d;
			4'h7: s = 8'h07;
			4'h8: s = 8'h7f;
			4'h9: s = 8'h6f;
			4'ha: s = 8'h77;
			4'hb: s = 8'h7c;
			4'hc: s = 8'h39;
			4'hd: s = 8'h5e;
			4'he: s = 8'h79;
			4'hf: s = 8'h71;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/slcd_front.sv @@
module slcd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  slcd_pkg::in_t        item,
	input  logic                 queue_full,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	output logic                 full,
	output slcd_pkg::frame_req_t req
);

	logic [7:0] digit_pair_q;
	logic       phase_q;
	logic       point_on_q;

	logic        accept;
	logic [15:0] prod;
	logic [4:0]  quot;
	logic [7:0]  rem;
	logic [7:0]  lo_seg;
	logic [7:0]  hi_seg;
	logic [7:0]  lo_byte;
	logic [7:0]  hi_byte;

	assign full = queue_full;
	assign accept = push && !queue_full;

	// Divide by ten through the reciprocal, remainder by subtract.
	assign prod = {8'd0, item.value} * {8'd0, slcd_pkg::DIV10_MUL};
	assign quot = prod[slcd_pkg::DIV10_SHIFT +: 5];
	assign rem = item.value - ({quot[4:0], 3'b000} + {2'b00, quot[4:0], 1'b0});

	assign lo_seg = slcd_pkg::seg_code(digit_pair_q[3:0]) | (point_on_q ? slcd_pkg::BP_BIT : 8'h00);
	assign hi_seg = slcd_pkg::seg_code(digit_pair_q[7:4]);

	always_comb begin
		if (phase_q) begin
			hi_byte = hi_seg & slcd_pkg::LOW7;
			lo_byte = lo_seg;
		end else begin
			hi_byte = ~hi_seg | slcd_pkg::BP_BIT;
			lo_byte = ~lo_seg;
		end
	end

	assign req.push = accept && (item.cmd == slcd_pkg::CMD_TICK);
	assign req.frame = {hi_byte, lo_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_pair_q <= 8'd0;
			phase_q <= 1'b0;
			point_on_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				point_on_q <= cfg_wdata;
			end
			if (accept) begin
				case (item.cmd)
					slcd_pkg::CMD_TICK: begin
						phase_q <= ~phase_q;
					end
					slcd_pkg::CMD_LOAD_DEC: begin
						digit_pair_q <= {quot[3:0], rem[3:0]};
					end
					slcd_pkg::CMD_LOAD_HEX: begin
						digit_pair_q <= item.value;
					end
					default: begin
						// drop the unused command
					end
				endcase
			end
		end
	end

endmodule

@@ rtl/slcd_frame_queue.sv @@
module slcd_frame_queue #(
	parameter int DEPTH = slcd_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slcd_pkg::frame_req_t  req,
	input  logic                  deq,
	output logic                  queue_full,
	output slcd_pkg::frame_head_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [slcd_pkg::FRAME_BITS-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign queue_full = (count_q == FULL_CNT);
	assign head.empty = (count_q == '0);
	assign head.frame = mem_q[rd_ptr_q];

	assign do_wr = req.push && !queue_full;
	assign do_rd = deq && !head.empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= req.frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/slcd_serializer.sv @@
module slcd_serializer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slcd_pkg::frame_head_t head,
	output logic                  deq,
	input  logic                  pop,
	output logic                  empty,
	output slcd_pkg::out_t        result
);

	localparam logic [slcd_pkg::CNT_W-1:0] LAST_BIT = slcd_pkg::CNT_W'(slcd_pkg::FRAME_BITS - 1);

	logic [slcd_pkg::FRAME_BITS-1:0] shift_q;
	logic [slcd_pkg::CNT_W-1:0]      cnt_q;
	logic                            active_q;
	logic                            out_valid_q;
	slcd_pkg::out_t                  out_q;

	logic slot_free;
	logic adv;
	logic last;
	logic load;

	assign slot_free = !out_valid_q || pop;
	assign adv = active_q && slot_free;
	assign last = (cnt_q == LAST_BIT);
	// Take the next frame when idle or as the last bit of this one leaves.
	assign deq = !active_q || (adv && last);
	assign load = deq && !head.empty;

	assign empty = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= head.frame;
		end else if (adv) begin
			shift_q <= {shift_q[slcd_pkg::FRAME_BITS-2:0], 1'b0};
		end
		if (adv) begin
			out_q.serial_bit <= shift_q[slcd_pkg::FRAME_BITS-1];
			out_q.strobe_after <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= '0;
				active_q <= 1'b1;
			end else if (adv) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					active_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/static_lcd_two_digit_driver.sv @@
// Serial drive for a two-digit static seven-segment LCD.
// Input queue side: push an item when full is low. A load item (decimal or
// hex) stores the display byte and yields nothing; a refresh tick builds one
// 16-bit shift register frame and flips the backplane phase.
// Result queue side: while empty is low, result holds the next serial bit;
// pop takes it. A tick yields 16 results, most significant bit first, and the
// last one has strobe_after set.
// A tick's frame is registered in the frame queue, then in the shift register,
// and each bit is registered before it is poppable. Throughput: one bit per
// cycle with pop held, set by the single-bit serializer. Loads: one per cycle unless full.
// Up to QUEUE_DEPTH built frames wait between the decoder and the
// serializer; once they are all taken, full rises and holds all input.
// A stall on pop holds the current result and fills the frame queue.
// Reset clears the display byte, the phase, the decimal point and all queues.
// cfg_we writes the decimal point enable; write it only while idle.
module static_lcd_two_digit_driver #(
	parameter int QUEUE_DEPTH = slcd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  slcd_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output slcd_pkg::out_t result,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);

	slcd_pkg::frame_req_t  req;
	slcd_pkg::frame_head_t head;
	logic                  queue_full;
	logic                  deq;

	slcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.queue_full (queue_full),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.full       (full),
		.req        (req)
	);

	slcd_frame_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.deq        (deq),
		.queue_full (queue_full),
		.head       (head)
	);

	slcd_serializer u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.deq    (deq),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

@@ rtl/slcd_checker.sv @@
`include "assert_macros.svh"

module slcd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           push,
	input logic           full,
	input slcd_pkg::in_t  item,
	input logic           empty,
	input logic           pop,
	input slcd_pkg::out_t result
);

	logic [7:0] pending_q;
	logic [3:0] bit_idx_q;
	logic       tick_in;
	logic       take;

	assign tick_in = push && !full && (item.cmd == slcd_pkg::CMD_TICK);
	assign take = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 8'd0;
			bit_idx_q <= 4'd0;
		end else begin
			pending_q <= pending_q + (tick_in ? 8'd16 : 8'd0) - (take ? 8'd1 : 8'd0);
			if (take) begin
				bit_idx_q <= bit_idx_q + 4'd1;
			end
		end
	end

	`SLCD_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> empty)
	`SLCD_ASSERT(a_no_extra_bits, clk, arst_n, !empty |-> (pending_q != 8'd0))
	`SLCD_ASSERT(a_strobe_place, clk, arst_n, take |-> (result.strobe_after == (bit_idx_q == 4'hf)))
	`SLCD_ASSERT(a_stall_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(result)))

endmodule

bind static_lcd_two_digit_driver slcd_checker u_slcd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_TAIL = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int SQUEEZE_TICKS = 8;
	localparam int PHASE_ITEMS = 110;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] value;
		logic typed;
		logic [15:0] frame;
	} row_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	slcd_pkg::in_t item;
	logic empty;
	logic pop;
	slcd_pkg::out_t result;
	logic cfg_we;
	logic cfg_wdata;

	// Shadow of the block: display byte, backplane phase, decimal point enable.
	logic [7:0] disp_byte = 8'h00;
	logic bp_phase = 1'b0;
	logic dp_en = 1'b0;

	logic [7:0] glyph [16] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
		8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
	};

	slcd_pkg::out_t pending_bits [$];
	int err_cnt = 0;
	int cycle_cnt = 0;

	logic cur_typed;
	logic [15:0] cur_frame;
	logic steady = 1'b0;
	logic hold_req = 1'b0;
	logic holding = 1'b0;

	// Typed frames follow the phase: after reset the first tick is the inverted one.
	row_t dir_rows [25] = '{
		'{slcd_pkg::CMD_TICK, 8'h00, 1'b1, 16'hC0C0},
		'{slcd_pkg::CMD_TICK, 8'hA5, 1'b1, 16'h3F3F},
		'{slcd_pkg::CMD_LOAD_HEX, 8'hFF, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_TICK, 8'h00, 1'b1, 16'h8E8E},
		'{slcd_pkg::CMD_TICK, 8'hFF, 1'b1, 16'h7171},
		'{slcd_pkg::CMD_LOAD_DEC, 8'd99, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_TICK, 8'h5A, 1'b1, 16'h9090},
		'{slcd_pkg::CMD_LOAD_DEC, 8'd255, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_TICK, 8'h00, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_LOAD_DEC, 8'd100, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_TICK, 8'h00, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_LOAD_DEC, 8'd0, 1'b0, 16'h0000},
		'{CMD_UNUSED, 8'hAA, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_TICK, 8'h00, 1'b1, 16'h3F3F},
		'{CMD_UNUSED, 8'h55, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_LOAD_HEX, 8'h23, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_TICK, 8'h00, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_LOAD_HEX, 8'h67, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_TICK, 8'h00, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_LOAD_HEX, 8'hAB, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_TICK, 8'h00, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_LOAD_HEX, 8'hEF, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_TICK, 8'h00, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_LOAD_DEC, 8'd10, 1'b0, 16'h0000},
		'{slcd_pkg::CMD_TICK, 8'h00, 1'b0, 16'h0000}
	};

	static_lcd_two_digit_driver dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	task automatic flag_mismatch(input string msg);
		err_cnt++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// Update the display byte on loads; expand a tick into its sixteen serial bits.
	task automatic predict_item(input slcd_pkg::in_t it, input logic typed,
			input logic [15:0] typed_frame);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] tens;
		logic [15:0] frame;
		slcd_pkg::out_t bit_out;
		case (it.cmd)
			slcd_pkg::CMD_LOAD_DEC: begin
				tens = (it.value / 8'd10) & 8'h0f;
				disp_byte = {tens[3:0], 4'(it.value % 8'd10)};
			end
			slcd_pkg::CMD_LOAD_HEX: begin
				disp_byte = it.value;
			end
			slcd_pkg::CMD_TICK: begin
				lo = glyph[disp_byte[3:0]];
				hi = glyph[disp_byte[7:4]];
				if (dp_en)
					lo = lo | slcd_pkg::BP_BIT;
				if (bp_phase)
					frame = {hi & slcd_pkg::LOW7, lo};
				else
					frame = {~hi | slcd_pkg::BP_BIT, ~lo};
				bp_phase = ~bp_phase;
				if (typed)
					frame = typed_frame;
				for (int k = 15; k >= 0; k--) begin
					bit_out.serial_bit = frame[k];
					bit_out.strobe_after = (k == 0);
					pending_bits.push_back(bit_out);
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_bit(input slcd_pkg::out_t got);
		slcd_pkg::out_t want;
		if (pending_bits.size() == 0) begin
			flag_mismatch("serial bit with nothing pending");
		end else begin
			want = pending_bits.pop_front();
			if (got.serial_bit !== want.serial_bit)
				flag_mismatch($sformatf("serial_bit got %b want %b",
					got.serial_bit, want.serial_bit));
			if (got.strobe_after !== want.strobe_after)
				flag_mismatch($sformatf("strobe_after got %b want %b",
					got.strobe_after, want.strobe_after));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				dp_en = cfg_wdata;
			if (push && !full)
				predict_item(item, cur_typed, cur_frame);
			if (pop && !empty)
				check_bit(result);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic offer_item(input slcd_pkg::in_t it, input logic typed,
			input logic [15:0] fr);
		@(negedge clk);
		push <= 1'b1;
		item <= it;
		cur_typed <= typed;
		cur_frame <= fr;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic sender_idle(input int n);
		@(negedge clk);
		push <= 1'b0;
		item <= slcd_pkg::in_t'(10'($urandom));
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (pending_bits.size() != 0)
			@(negedge clk);
	endtask

	// Write only with nothing in flight: loads leave no trace, so give them time to settle.
	task automatic write_point(input logic v);
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic slcd_pkg::in_t rand_item();
		slcd_pkg::in_t it;
		int r;
		r = $urandom_range(0, 19);
		it.value = 8'($urandom_range(0, 255));
		if (r < 9)
			it.cmd = slcd_pkg::CMD_TICK;
		else if (r < 14)
			it.cmd = slcd_pkg::CMD_LOAD_DEC;
		else if (r < 19)
			it.cmd = slcd_pkg::CMD_LOAD_HEX;
		else
			it.cmd = CMD_UNUSED;
		return it;
	endfunction

	// Stall the result side and offer SQUEEZE_TICKS ticks so that input backs up.
	task automatic squeeze_queue();
		slcd_pkg::in_t it;
		hold_req = 1'b1;
		while (!holding)
			@(posedge clk);
		for (int i = 0; i < SQUEEZE_TICKS; i++) begin
			it.cmd = slcd_pkg::CMD_TICK;
			it.value = 8'($urandom);
			offer_item(it, 1'b0, 16'h0000);
		end
	endtask

	task automatic random_run(input int n, input int pressure);
		slcd_pkg::in_t it;
		int counted;
		counted = 0;
		while (counted < n) begin
			if (counted == n / 2 && pressure == 1) begin
				squeeze_queue();
				counted += SQUEEZE_TICKS;
			end else if (counted == n / 2 && pressure == 2) begin
				wait_drained();
				sender_idle($urandom_range(1, 17));
			end
			it = rand_item();
			offer_item(it, 1'b0, 16'h0000);
			if (it.cmd != CMD_UNUSED)
				counted++;
			if (!steady && (counted % 40) < 30 && $urandom_range(0, 3) == 0)
				sender_idle($urandom_range(1, 17));
		end
	endtask

	initial begin
		int n;
		pop = 1'b0;
		while (arst_n !== 1'b1)
			@(negedge clk);
		forever begin
			if (hold_req) begin
				@(negedge clk);
				pop <= 1'b0;
				holding = 1'b1;
				repeat (HOLD_CYCLES - 1)
					@(negedge clk);
				holding = 1'b0;
				hold_req = 1'b0;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 17);
				@(negedge clk);
				pop <= 1'b0;
				repeat (n - 1)
					@(negedge clk);
			end else begin
				n = $urandom_range(1, 40);
				@(negedge clk);
				pop <= 1'b1;
				repeat (n - 1)
					@(negedge clk);
			end
		end
	end

	initial begin
		slcd_pkg::in_t it;
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		cur_typed = 1'b0;
		cur_frame = 16'h0000;
		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			it.cmd = dir_rows[i].cmd;
			it.value = dir_rows[i].value;
			offer_item(it, dir_rows[i].typed, dir_rows[i].frame);
			if ($urandom_range(0, 2) == 0)
				sender_idle($urandom_range(1, 17));
		end

		write_point(1'b1);
		random_run(PHASE_ITEMS, 1);
		write_point(1'b0);
		random_run(PHASE_ITEMS, 2);
		write_point(1'b1);
		random_run(PHASE_ITEMS, 0);
		write_point(1'b0);
		steady = 1'b1;
		random_run(PHASE_ITEMS, 0);

		wait_drained();
		repeat (DRAIN_TAIL)
			@(posedge clk);
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
